// File: sv/guide_overlay_pixel_blend_defines.svh
`ifndef GUIDE_OVERLAY_PIXEL_BLEND_DEFINES_SVH
`define GUIDE_OVERLAY_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define GOA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("guide overlay assertion failed");

// next-cycle implication on clk_i, off during reset
`define GOA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("guide overlay assertion failed");

`endif

// File: sv/goa_pkg.sv
`default_nettype none

package goa_pkg;

  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned DimW       = $clog2(MaxDim) + 1;
  localparam int unsigned PosW       = 12;
  localparam int unsigned NumCells   = 4;
  localparam int unsigned HitW       = $clog2(NumCells + 1);
  localparam int unsigned AddrW      = 5;
  localparam int unsigned ThirdShift = 15;

  localparam logic [DimW-1:0]       MaxDimV  = DimW'(MaxDim);
  localparam logic [ThirdShift-1:0] ThirdMul = ThirdShift'(10923);
  localparam logic [7:0]            DimKeep  = 8'd215;
  localparam logic [7:0]            ChanMax  = 8'hFF;

  typedef enum logic [1:0] {
    ModeThirds = 2'd0,
    ModeCross  = 2'd1,
    ModeSafe   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    RegMode   = 3'd0,
    RegWidth  = 3'd1,
    RegHeight = 3'd2,
    RegLeft   = 3'd3,
    RegRight  = 3'd4,
    RegTop    = 3'd5,
    RegBottom = 3'd6,
    RegColor  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t           pix;
    logic [HitW-1:0] hits;
    logic            dim;
  } item_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [DimW-1:0] frame_width;
    logic [DimW-1:0] frame_height;
    logic [DimW-1:0] left_bound;
    logic [DimW-1:0] right_bound;
    logic [DimW-1:0] top_bound;
    logic [DimW-1:0] bottom_bound;
    rgba_t           color;
  } cfg_t;

  // exact floor(n / 255) for n up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] s;
    s = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
    return s[15:8];
  endfunction

  function automatic logic [7:0] mix_chan(input logic [7:0] c, input logic [7:0] p,
                                          input logic [7:0] a);
    logic [15:0] ca;
    logic [15:0] pb;
    ca = {8'd0, c} * {8'd0, a};
    pb = {8'd0, p} * {8'd0, ChanMax - a};
    return div255(ca + pb);
  endfunction

  function automatic logic [7:0] dim_chan(input logic [7:0] p);
    return div255({8'd0, p} * {8'd0, DimKeep});
  endfunction

endpackage

`default_nettype wire

// File: sv/goa_front.sv
`default_nettype none

module goa_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire logic [goa_pkg::PosW-1:0]   pos_x_i,
  input  wire logic [goa_pkg::PosW-1:0]   pos_y_i,
  input  wire goa_pkg::rgba_t             pix_i,
  input  wire goa_pkg::cfg_t              cfg_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output goa_pkg::item_t                  item_o
);

  localparam int unsigned DW = goa_pkg::DimW;
  localparam int unsigned TS = goa_pkg::ThirdShift;

  logic [DW-1:0]         w, h, x, y;
  logic [DW+TS-1:0]      wp1, hp1;
  logic [DW+TS:0]        wp2, hp2;
  logic [DW-1:0]         w_t1, w_t2, h_t1, h_t2;
  logic [DW-1:0]         lr_lo, lr_hi, tb_lo, tb_hi;
  logic                  in_frame, hx, vy;
  logic [3:0]            hit;
  logic                  dim;
  logic                  valid_q;
  goa_pkg::item_t        item_q, item_d;

  always_comb begin
    w = (cfg_i.frame_width > goa_pkg::MaxDimV) ? goa_pkg::MaxDimV : cfg_i.frame_width;
    h = (cfg_i.frame_height > goa_pkg::MaxDimV) ? goa_pkg::MaxDimV : cfg_i.frame_height;
    x = {1'b0, pos_x_i};
    y = {1'b0, pos_y_i};
    in_frame = (x < w) && (y < h);

    wp1 = {{TS{1'b0}}, w} * {{DW{1'b0}}, goa_pkg::ThirdMul};
    hp1 = {{TS{1'b0}}, h} * {{DW{1'b0}}, goa_pkg::ThirdMul};
    wp2 = {{TS{1'b0}}, w, 1'b0} * {{(DW+1){1'b0}}, goa_pkg::ThirdMul};
    hp2 = {{TS{1'b0}}, h, 1'b0} * {{(DW+1){1'b0}}, goa_pkg::ThirdMul};
    w_t1 = wp1[TS +: DW];
    h_t1 = hp1[TS +: DW];
    w_t2 = wp2[TS +: DW];
    h_t2 = hp2[TS +: DW];

    lr_lo = (cfg_i.left_bound < cfg_i.right_bound) ? cfg_i.left_bound : cfg_i.right_bound;
    lr_hi = (cfg_i.left_bound < cfg_i.right_bound) ? cfg_i.right_bound : cfg_i.left_bound;
    tb_lo = (cfg_i.top_bound < cfg_i.bottom_bound) ? cfg_i.top_bound : cfg_i.bottom_bound;
    tb_hi = (cfg_i.top_bound < cfg_i.bottom_bound) ? cfg_i.bottom_bound : cfg_i.top_bound;
    hx = (x >= lr_lo) && (x <= lr_hi);
    vy = (y >= tb_lo) && (y <= tb_hi);

    hit = '0;
    dim = 1'b0;
    if (in_frame) begin
      case (cfg_i.mode)
        goa_pkg::ModeThirds: begin
          hit = {x == w_t1, x == w_t2, y == h_t1, y == h_t2};
        end
        goa_pkg::ModeCross: begin
          hit = {x == (w >> 1), y == (h >> 1), 2'b00};
        end
        goa_pkg::ModeSafe: begin
          hit = {(y == cfg_i.top_bound) && hx, (y == cfg_i.bottom_bound) && hx,
                 (x == cfg_i.left_bound) && vy, (x == cfg_i.right_bound) && vy};
          dim = (y < cfg_i.top_bound) || (y > cfg_i.bottom_bound) ||
                (x < cfg_i.left_bound) || (x > cfg_i.right_bound);
        end
        default: begin
          hit = '0;
          dim = 1'b0;
        end
      endcase
    end

    item_d.pix  = pix_i;
    item_d.hits = goa_pkg::HitW'(hit[0]) + goa_pkg::HitW'(hit[1]) +
                  goa_pkg::HitW'(hit[2]) + goa_pkg::HitW'(hit[3]);
    item_d.dim  = dim;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: sv/goa_cell.sv
`default_nettype none

module goa_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire goa_pkg::item_t item_i,
  input  wire goa_pkg::rgba_t color_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output goa_pkg::item_t      item_o
);

  logic           valid_q;
  goa_pkg::item_t item_q, item_d;

  // blend once while line hits remain, then hand the rest down the row
  always_comb begin
    item_d = item_i;
    if (item_i.hits != '0) begin
      item_d.pix.red   = goa_pkg::mix_chan(color_i.red,   item_i.pix.red,   color_i.alpha);
      item_d.pix.green = goa_pkg::mix_chan(color_i.green, item_i.pix.green, color_i.alpha);
      item_d.pix.blue  = goa_pkg::mix_chan(color_i.blue,  item_i.pix.blue,  color_i.alpha);
      item_d.pix.alpha = goa_pkg::ChanMax;
      item_d.hits      = item_i.hits - goa_pkg::HitW'(1);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: sv/goa_dim.sv
`default_nettype none

module goa_dim (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire goa_pkg::item_t item_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output goa_pkg::rgba_t      pix_o
);

  logic           valid_q;
  goa_pkg::rgba_t pix_q, pix_d;

  always_comb begin
    pix_d = item_i.pix;
    if (item_i.dim) begin
      pix_d.red   = goa_pkg::dim_chan(item_i.pix.red);
      pix_d.green = goa_pkg::dim_chan(item_i.pix.green);
      pix_d.blue  = goa_pkg::dim_chan(item_i.pix.blue);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

// File: sv/guide_overlay_pixel_blend.sv
// Stages: classify, four blend cells, dim; each a one-entry register with its own valid.
// Throughput: one item per cycle whenever the output is not stalled.
// Stalls back up stage by stage, so empty stages keep taking items while the output waits.
// Reset: rst_ni async active low clears all stage valids and loads the register defaults
// (mode thirds, 1920 x 1080, bounds 0, color 0xFFFFFFFF).
`default_nettype none
`include "guide_overlay_pixel_blend_defines.svh"

module guide_overlay_pixel_blend (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [goa_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [goa_pkg::PosW-1:0]    pos_x_i,
  input  wire logic [goa_pkg::PosW-1:0]    pos_y_i,
  input  wire logic [7:0]                  in_red_i,
  input  wire logic [7:0]                  in_green_i,
  input  wire logic [7:0]                  in_blue_i,
  input  wire logic [7:0]                  in_alpha_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       out_red_o,
  output logic [7:0]                       out_green_o,
  output logic [7:0]                       out_blue_o,
  output logic [7:0]                       out_alpha_o
);

  localparam int unsigned NC = goa_pkg::NumCells;
  localparam int unsigned DW = goa_pkg::DimW;

  goa_pkg::cfg_t     cfg_q;
  logic              cfg_wr;
  goa_pkg::reg_idx_e reg_sel;
  goa_pkg::rgba_t    in_pix, out_pix;

  logic              link_valid [NC+1];
  logic              link_ready [NC+1];
  goa_pkg::item_t    link_item  [NC+1];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = goa_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= goa_pkg::ModeThirds;
      cfg_q.frame_width  <= DW'(1920);
      cfg_q.frame_height <= DW'(1080);
      cfg_q.left_bound   <= '0;
      cfg_q.right_bound  <= '0;
      cfg_q.top_bound    <= '0;
      cfg_q.bottom_bound <= '0;
      cfg_q.color        <= '1;
    end else if (cfg_wr) begin
      case (reg_sel)
        goa_pkg::RegMode:   cfg_q.mode         <= pwdata[1:0];
        goa_pkg::RegWidth:  cfg_q.frame_width  <= pwdata[DW-1:0];
        goa_pkg::RegHeight: cfg_q.frame_height <= pwdata[DW-1:0];
        goa_pkg::RegLeft:   cfg_q.left_bound   <= pwdata[DW-1:0];
        goa_pkg::RegRight:  cfg_q.right_bound  <= pwdata[DW-1:0];
        goa_pkg::RegTop:    cfg_q.top_bound    <= pwdata[DW-1:0];
        goa_pkg::RegBottom: cfg_q.bottom_bound <= pwdata[DW-1:0];
        goa_pkg::RegColor:  cfg_q.color        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      goa_pkg::RegMode:   prdata = {30'd0, cfg_q.mode};
      goa_pkg::RegWidth:  prdata = {{(32-DW){1'b0}}, cfg_q.frame_width};
      goa_pkg::RegHeight: prdata = {{(32-DW){1'b0}}, cfg_q.frame_height};
      goa_pkg::RegLeft:   prdata = {{(32-DW){1'b0}}, cfg_q.left_bound};
      goa_pkg::RegRight:  prdata = {{(32-DW){1'b0}}, cfg_q.right_bound};
      goa_pkg::RegTop:    prdata = {{(32-DW){1'b0}}, cfg_q.top_bound};
      goa_pkg::RegBottom: prdata = {{(32-DW){1'b0}}, cfg_q.bottom_bound};
      goa_pkg::RegColor:  prdata = cfg_q.color;
      default:            prdata = '0;
    endcase
  end

  assign in_pix = '{red: in_red_i, green: in_green_i, blue: in_blue_i, alpha: in_alpha_i};

  goa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pix_i   (in_pix),
    .cfg_i   (cfg_q),
    .valid_o (link_valid[0]),
    .ready_i (link_ready[0]),
    .item_o  (link_item[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    goa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[k]),
      .ready_o (link_ready[k]),
      .item_i  (link_item[k]),
      .color_i (cfg_q.color),
      .valid_o (link_valid[k+1]),
      .ready_i (link_ready[k+1]),
      .item_o  (link_item[k+1])
    );
  end

  goa_dim u_dim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[NC]),
    .ready_o (link_ready[NC]),
    .item_i  (link_item[NC]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pix_o   (out_pix)
  );

  assign out_red_o   = out_pix.red;
  assign out_green_o = out_pix.green;
  assign out_blue_o  = out_pix.blue;
  assign out_alpha_o = out_pix.alpha;

  `GOA_ASSERT_NXT(a_accept_enters, in_valid_i && in_ready_o, link_valid[0])
  `GOA_ASSERT_IMP(a_hits_bounded, link_valid[0], link_item[0].hits <= goa_pkg::HitW'(NC))
  `GOA_ASSERT_IMP(a_hits_consumed, link_valid[NC], link_item[NC].hits == '0)
  `GOA_ASSERT_NXT(a_mode_write, cfg_wr && (reg_sel == goa_pkg::RegMode),
                  cfg_q.mode == $past(pwdata[1:0]))

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [goa_pkg::PosW-1:0] pos_x;
    logic [goa_pkg::PosW-1:0] pos_y;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [7:0]               alpha;
  } pixel_t;

  typedef struct {
    logic [1:0]  mode;
    logic [12:0] width;
    logic [12:0] height;
    logic [12:0] left_col;
    logic [12:0] right_col;
    logic [12:0] top_row;
    logic [12:0] bottom_row;
    logic [31:0] color;
  } guide_regs_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [goa_pkg::AddrW-1:0] paddr = '0;
  logic [31:0]               pwdata = '0;
  wire  [31:0]               prdata;
  wire                       pready;
  logic                      in_valid_i = 1'b0;
  wire                       in_ready_o;
  logic [goa_pkg::PosW-1:0]  pos_x_i = '0;
  logic [goa_pkg::PosW-1:0]  pos_y_i = '0;
  logic [7:0]                in_red_i = '0;
  logic [7:0]                in_green_i = '0;
  logic [7:0]                in_blue_i = '0;
  logic [7:0]                in_alpha_i = '0;
  wire                       out_valid_o;
  logic                      out_ready_i = 1'b0;
  wire  [7:0]                out_red_o;
  wire  [7:0]                out_green_o;
  wire  [7:0]                out_blue_o;
  wire  [7:0]                out_alpha_o;

  guide_regs_t    guide = '{mode: 2'd0, width: 13'd1920, height: 13'd1080, left_col: 13'd0,
                            right_col: 13'd0, top_row: 13'd0, bottom_row: 13'd0,
                            color: 32'hFFFF_FFFF};
  goa_pkg::rgba_t expected_pixels[$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             hold_cycles = 0;
  bit             steady = 1'b0;

  guide_overlay_pixel_blend DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .in_alpha_i  (in_alpha_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic pixel_t mk_pixel(input int unsigned x, input int unsigned y,
                                      input int unsigned r, input int unsigned g,
                                      input int unsigned b, input int unsigned a);
    pixel_t px;
    px.pos_x = x[goa_pkg::PosW-1:0];
    px.pos_y = y[goa_pkg::PosW-1:0];
    px.red   = r[7:0];
    px.green = g[7:0];
    px.blue  = b[7:0];
    px.alpha = a[7:0];
    return px;
  endfunction

  function automatic goa_pkg::rgba_t overlay_pixel(input pixel_t px);
    int unsigned    w, h, x, y, hits, opacity, lo, hi;
    int unsigned    chan[3];
    int unsigned    tint[3];
    bit             span_x, span_y, dim;
    goa_pkg::rgba_t res;
    w = (guide.width > goa_pkg::MaxDim) ? goa_pkg::MaxDim : guide.width;
    h = (guide.height > goa_pkg::MaxDim) ? goa_pkg::MaxDim : guide.height;
    x = px.pos_x;
    y = px.pos_y;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    tint[0] = guide.color[31:24];
    tint[1] = guide.color[23:16];
    tint[2] = guide.color[15:8];
    opacity = guide.color[7:0];
    hits = 0;
    dim = 1'b0;
    if (x < w && y < h) begin
      case (guide.mode)
        goa_pkg::ModeThirds: begin
          hits = int'(x == w / 3) + int'(x == (2 * w) / 3) +
                 int'(y == h / 3) + int'(y == (2 * h) / 3);
        end
        goa_pkg::ModeCross: begin
          hits = int'(x == w / 2) + int'(y == h / 2);
        end
        goa_pkg::ModeSafe: begin
          lo = (guide.left_col < guide.right_col) ? guide.left_col : guide.right_col;
          hi = (guide.left_col < guide.right_col) ? guide.right_col : guide.left_col;
          span_x = (x >= lo) && (x <= hi);
          lo = (guide.top_row < guide.bottom_row) ? guide.top_row : guide.bottom_row;
          hi = (guide.top_row < guide.bottom_row) ? guide.bottom_row : guide.top_row;
          span_y = (y >= lo) && (y <= hi);
          hits = int'(y == guide.top_row && span_x) + int'(y == guide.bottom_row && span_x) +
                 int'(x == guide.left_col && span_y) + int'(x == guide.right_col && span_y);
          dim = (y < guide.top_row) || (y > guide.bottom_row) ||
                (x < guide.left_col) || (x > guide.right_col);
        end
        default: ;
      endcase
    end
    for (int k = 0; k < hits; k++)
      for (int i = 0; i < 3; i++)
        chan[i] = (tint[i] * opacity + chan[i] * (255 - opacity)) / 255;
    if (dim)
      for (int i = 0; i < 3; i++)
        chan[i] = (chan[i] * goa_pkg::DimKeep) / 255;
    res.red   = chan[0][7:0];
    res.green = chan[1][7:0];
    res.blue  = chan[2][7:0];
    res.alpha = (hits > 0) ? goa_pkg::ChanMax : px.alpha;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
  endtask

  always @(posedge clk_i) begin : check_output
    goa_pkg::rgba_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected item, red", out_red_o, 8'd0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_red_o !== want.red)     report_mismatch("red", out_red_o, want.red);
        if (out_green_o !== want.green) report_mismatch("green", out_green_o, want.green);
        if (out_blue_o !== want.blue)   report_mismatch("blue", out_blue_o, want.blue);
        if (out_alpha_o !== want.alpha) report_mismatch("alpha", out_alpha_o, want.alpha);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic send_pixel(input pixel_t px);
    if (!steady && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 24);
    end
    pos_x_i    <= px.pos_x;
    pos_y_i    <= px.pos_y;
    in_red_i   <= px.red;
    in_green_i <= px.green;
    in_blue_i  <= px.blue;
    in_alpha_i <= px.alpha;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pixels.push_back(overlay_pixel(px));
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input goa_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= goa_pkg::AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      goa_pkg::RegMode:   guide.mode       = value[1:0];
      goa_pkg::RegWidth:  guide.width      = value[12:0];
      goa_pkg::RegHeight: guide.height     = value[12:0];
      goa_pkg::RegLeft:   guide.left_col   = value[12:0];
      goa_pkg::RegRight:  guide.right_col  = value[12:0];
      goa_pkg::RegTop:    guide.top_row    = value[12:0];
      goa_pkg::RegBottom: guide.bottom_row = value[12:0];
      goa_pkg::RegColor:  guide.color      = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_bounds(input int unsigned l, input int unsigned r,
                            input int unsigned t, input int unsigned b);
    write_reg(goa_pkg::RegLeft, l);
    write_reg(goa_pkg::RegRight, r);
    write_reg(goa_pkg::RegTop, t);
    write_reg(goa_pkg::RegBottom, b);
  endtask

  function automatic int unsigned pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    if (sel == 0) return 0;
    if (sel < 3)  return $urandom_range(1, 8);
    if (sel < 7)  return $urandom_range(1, 64);
    if (sel < 9)  return $urandom_range(1, 4096);
    if (sel < 11) return 4096;
    return $urandom_range(4097, 8191);
  endfunction

  function automatic int unsigned pick_bound(input int unsigned dim);
    if ($urandom_range(0, 9) == 0 || dim == 0) return $urandom_range(0, 8191);
    return $urandom_range(0, dim - 1);
  endfunction

  function automatic logic [7:0] pick_chan();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [goa_pkg::PosW-1:0] pick_coord(input int unsigned lim,
                                                          input int unsigned m0,
                                                          input int unsigned m1,
                                                          input int unsigned m2,
                                                          input int unsigned m3,
                                                          input int unsigned m4);
    int unsigned marks[5];
    int unsigned sel, v;
    marks = '{m0, m1, m2, m3, m4};
    sel = $urandom_range(0, 11);
    if (sel < 6)
      v = marks[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1;
    else if (sel < 10 && lim > 0)
      v = $urandom_range(0, lim - 1);
    else
      v = $urandom_range(0, 4095);
    return v[goa_pkg::PosW-1:0];
  endfunction

  function automatic pixel_t random_pixel();
    int unsigned w, h;
    pixel_t      px;
    w = (guide.width > goa_pkg::MaxDim) ? goa_pkg::MaxDim : guide.width;
    h = (guide.height > goa_pkg::MaxDim) ? goa_pkg::MaxDim : guide.height;
    px.pos_x = pick_coord(w, w / 3, (2 * w) / 3, w / 2, guide.left_col, guide.right_col);
    px.pos_y = pick_coord(h, h / 3, (2 * h) / 3, h / 2, guide.top_row, guide.bottom_row);
    px.red   = pick_chan();
    px.green = pick_chan();
    px.blue  = pick_chan();
    px.alpha = pick_chan();
    return px;
  endfunction

  task automatic randomize_guide();
    int unsigned sel, w, h;
    logic [31:0] color;
    sel = $urandom_range(0, 9);
    w = pick_dim();
    h = pick_dim();
    color = $urandom;
    case ($urandom_range(0, 3))
      0: color[7:0] = 8'h00;
      1: color[7:0] = 8'hFF;
      default: ;
    endcase
    if (sel < 3)      write_reg(goa_pkg::RegMode, 32'(goa_pkg::ModeThirds));
    else if (sel < 5) write_reg(goa_pkg::RegMode, 32'(goa_pkg::ModeCross));
    else if (sel < 9) write_reg(goa_pkg::RegMode, 32'(goa_pkg::ModeSafe));
    else              write_reg(goa_pkg::RegMode, 32'd3);
    write_reg(goa_pkg::RegWidth, w);
    write_reg(goa_pkg::RegHeight, h);
    w = (w > goa_pkg::MaxDim) ? goa_pkg::MaxDim : w;
    h = (h > goa_pkg::MaxDim) ? goa_pkg::MaxDim : h;
    set_bounds(pick_bound(w), pick_bound(w), pick_bound(h), pick_bound(h));
    write_reg(goa_pkg::RegColor, color);
  endtask

  task automatic test_default_thirds();
    send_pixel(mk_pixel(640, 360, 0, 0, 0, 0));
    send_pixel(mk_pixel(1280, 720, 255, 255, 255, 0));
    send_pixel(mk_pixel(0, 0, 12, 34, 56, 78));
    send_pixel(mk_pixel(1919, 1079, 255, 0, 255, 0));
    send_pixel(mk_pixel(1920, 360, 1, 2, 3, 4));
    send_pixel(mk_pixel(4095, 4095, 255, 255, 255, 255));
    drain_pipeline();
    write_reg(goa_pkg::RegColor, 32'h1080_F07F);
    send_pixel(mk_pixel(640, 720, 255, 0, 128, 9));
    send_pixel(mk_pixel(640, 5, 0, 255, 7, 200));
    drain_pipeline();
  endtask

  task automatic test_crosshair();
    write_reg(goa_pkg::RegMode, 32'(goa_pkg::ModeCross));
    send_pixel(mk_pixel(960, 540, 0, 0, 0, 0));
    send_pixel(mk_pixel(960, 100, 200, 100, 50, 25));
    send_pixel(mk_pixel(100, 540, 255, 255, 255, 255));
    drain_pipeline();
  endtask

  task automatic test_safe_zone();
    write_reg(goa_pkg::RegMode, 32'(goa_pkg::ModeSafe));
    set_bounds(100, 200, 50, 150);
    send_pixel(mk_pixel(100, 50, 0, 0, 0, 0));
    send_pixel(mk_pixel(150, 100, 99, 98, 97, 96));
    send_pixel(mk_pixel(150, 150, 255, 255, 255, 1));
    send_pixel(mk_pixel(10, 10, 255, 255, 255, 255));
    send_pixel(mk_pixel(100, 200, 255, 128, 1, 17));
    send_pixel(mk_pixel(300, 50, 77, 66, 55, 44));
    drain_pipeline();
    // swapped left and right: every column counts as outside
    set_bounds(200, 100, 50, 150);
    send_pixel(mk_pixel(150, 100, 255, 255, 255, 3));
    send_pixel(mk_pixel(200, 100, 0, 40, 80, 5));
    drain_pipeline();
    set_bounds(7, 7, 7, 7);
    send_pixel(mk_pixel(7, 7, 0, 128, 255, 0));
    drain_pipeline();
  endtask

  task automatic test_frame_edges();
    write_reg(goa_pkg::RegMode, 32'(goa_pkg::ModeThirds));
    write_reg(goa_pkg::RegWidth, 1);
    write_reg(goa_pkg::RegHeight, 1);
    send_pixel(mk_pixel(0, 0, 255, 0, 0, 0));
    drain_pipeline();
    write_reg(goa_pkg::RegWidth, 0);
    send_pixel(mk_pixel(0, 0, 1, 2, 3, 4));
    drain_pipeline();
    write_reg(goa_pkg::RegWidth, 8191);
    write_reg(goa_pkg::RegHeight, 8191);
    send_pixel(mk_pixel(1365, 2730, 10, 20, 30, 40));
    drain_pipeline();
    write_reg(goa_pkg::RegMode, 32'd3);
    send_pixel(mk_pixel(1365, 1365, 90, 80, 70, 60));
    drain_pipeline();
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 5; phase++) begin
      randomize_guide();
      for (int n = 0; n < 100; n++) send_pixel(random_pixel());
      drain_pipeline();
    end
  endtask

  task automatic test_output_stall();
    write_reg(goa_pkg::RegMode, 32'(goa_pkg::ModeThirds));
    write_reg(goa_pkg::RegWidth, 30);
    write_reg(goa_pkg::RegHeight, 30);
    steady = 1'b1;
    hold_cycles = 80;
    for (int n = 0; n < 40; n++) send_pixel(random_pixel());
    steady = 1'b0;
    drain_pipeline();
  endtask

  task automatic test_steady_stream();
    randomize_guide();
    steady = 1'b1;
    for (int n = 0; n < 120; n++) send_pixel(random_pixel());
    steady = 1'b0;
    drain_pipeline();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_thirds();
    test_crosshair();
    test_safe_zone();
    test_frame_edges();
    test_random_configs();
    test_output_stall();
    test_steady_stream();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/goa_pkg.sv
sv/goa_front.sv
sv/goa_cell.sv
sv/goa_dim.sv
sv/guide_overlay_pixel_blend.sv
tb/testbench.sv
